>>> hw/rtl/lzcsd_pkg.sv
`timescale 1ns / 1ps
package lzcsd_pkg;
  localparam int HIST_DEPTH_DEF = 65536;
  localparam int MAX_IN_DEF = 32768;

  typedef enum logic [2:0] {
    ST_DATA = 3'd0,
    ST_ACC  = 3'd1,
    ST_NEED = 3'd2,
    ST_BUSY = 3'd3,
    ST_END  = 3'd4,
    ST_ERR  = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    CMD_LIT  = 3'd0,
    CMD_FILL = 3'd1,
    CMD_WORD = 3'd2,
    CMD_INC  = 3'd3,
    CMD_ABS  = 3'd4,
    CMD_IABS = 3'd5,
    CMD_BACK = 3'd6,
    CMD_IBCK = 3'd7
  } cmd_t;

  localparam logic [7:0] END_HDR = 8'hFF;
endpackage

>>> hw/rtl/lzcsd_if.sv
`timescale 1ns / 1ps
interface lzcsd_req_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] in_byte;
  modport source (output valid, req_type, in_byte, input ready);
  modport sink (input valid, req_type, in_byte, output ready);
endinterface

interface lzcsd_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [7:0]  out_byte;
  logic [16:0] out_count;
  modport source (output valid, status, out_byte, out_count, input ready);
  modport sink (input valid, status, out_byte, out_count, output ready);
endinterface

>>> hw/rtl/lzcsd_hist_mem.sv
`timescale 1ns / 1ps
// History memory: one write port, one registered read port.
module lzcsd_hist_mem #(
  parameter int DEPTH = lzcsd_pkg::HIST_DEPTH_DEF,
  parameter int AW = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);
  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end
endmodule

>>> hw/rtl/lz_command_stream_decompressor_core.sv
`timescale 1ns / 1ps
// Header-driven LZ stream decompressor.
// Channel req: each transfer either feeds one compressed byte (req_type 0)
// or pulls one decoded byte (req_type 1). Channel rsp: exactly one result
// transfer per request, carrying status, decoded byte and running count.
// Throughput: one request per cycle while the receiver does not stall;
// the result is registered and appears in the output register in the
// cycle after the request is taken. A copy pull looks ahead: the history
// byte for the next pull is read from the registered-read memory once the
// source address is known; a byte just written there is forwarded from the
// write path, so copies overlapping their own output run at one byte per cycle.
// When the receiver stalls, the output register holds and req.ready drops
// until the result is taken; a new request is taken in the cycle the old
// result leaves.
// Reset (rst, synchronous) clears all control state and counts; history is
// not cleared, since every copy source is checked against the byte count.
// After stream end or error every request answers that status until reset.
module lz_command_stream_decompressor_core #(
  parameter int HIST_DEPTH = lzcsd_pkg::HIST_DEPTH_DEF,
  parameter int MAX_IN = lzcsd_pkg::MAX_IN_DEF
) (
  input logic clk,
  input logic rst,
  lzcsd_req_if.sink req,
  lzcsd_rsp_if.source rsp
);
  localparam int AW = $clog2(HIST_DEPTH);

  typedef enum logic [2:0] {
    PH_HDR, PH_LONG, PH_OPA, PH_OPB, PH_RUN, PH_LITW, PH_LITH, PH_END
  } phase_t;

  phase_t      phase;
  logic        failed;
  logic [16:0] produced;
  logic [15:0] consumed;
  logic [2:0]  cmd;
  logic [10:0] run_left;
  logic [7:0]  fill_first, fill_second;
  logic [15:0] copy_src;
  logic        parity;

  logic        acc;
  assign req.ready = !rsp.valid || rsp.ready;
  assign acc = req.valid && req.ready;

  // Read port: the address being read is the next copy source
  logic          re;
  logic [AW-1:0] raddr;
  logic [7:0]    rdata;
  logic          we;
  logic [AW-1:0] waddr;
  logic [7:0]    wdata;
  logic          fwd;
  logic [7:0]    fwd_data;
  logic [15:0]   rd_src;

  lzcsd_hist_mem #(.DEPTH(HIST_DEPTH), .AW(AW)) u_mem (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .re(re), .raddr(raddr), .rdata(rdata)
  );

  // Next-state logic
  phase_t      phase_next;
  logic        failed_next;
  logic [16:0] produced_next;
  logic [15:0] consumed_next;
  logic [2:0]  cmd_next;
  logic [10:0] run_left_next;
  logic [7:0]  ff_next, fs_next;
  logic [15:0] src_next;
  logic        parity_next;
  logic [2:0]  st;
  logic [7:0]  ob;
  logic [7:0]  hist_byte;
  logic [10:0] rl_dec;
  logic [7:0]  b;
  logic        in_range;

  assign b = req.in_byte;
  assign hist_byte = fwd ? fwd_data : rdata;
  assign rl_dec = (run_left != 11'd0) ? run_left - 11'd1 : 11'd0;
  assign in_range = ({1'b0, copy_src} < 17'(HIST_DEPTH)) && (rd_src == copy_src);

  always_comb begin
    phase_next = phase; failed_next = failed; produced_next = produced;
    consumed_next = consumed; cmd_next = cmd; run_left_next = run_left;
    ff_next = fill_first; fs_next = fill_second; src_next = copy_src;
    parity_next = parity; st = lzcsd_pkg::ST_ACC; ob = 8'd0;
    we = 1'b0; wdata = 8'd0;
    waddr = produced[AW-1:0];
    if (phase == PH_END) begin
      st = failed ? lzcsd_pkg::ST_ERR : lzcsd_pkg::ST_END;
    end else if (phase == PH_HDR && {16'd0, consumed} >= 32'(MAX_IN)) begin
      st = lzcsd_pkg::ST_END; phase_next = PH_END; failed_next = 1'b0;
    end else if (req.req_type) begin
      if (phase == PH_RUN || phase == PH_LITH) begin
        if (produced >= 17'(HIST_DEPTH)) begin
          st = lzcsd_pkg::ST_END; phase_next = PH_END; failed_next = 1'b0;
        end else begin
          st = lzcsd_pkg::ST_DATA;
          if (phase == PH_LITH) ob = fill_first;
          else begin
            case (cmd)
              lzcsd_pkg::CMD_FILL: ob = fill_first;
              lzcsd_pkg::CMD_WORD: begin
                ob = parity ? fill_second : fill_first;
                parity_next = !parity;
              end
              lzcsd_pkg::CMD_INC: begin
                ob = fill_first; ff_next = fill_first + 8'd1;
              end
              lzcsd_pkg::CMD_ABS, lzcsd_pkg::CMD_BACK: begin
                ob = in_range ? hist_byte : 8'd0; src_next = copy_src + 16'd1;
              end
              default: begin
                ob = (in_range ? hist_byte : 8'd0) ^ 8'hFF;
                src_next = copy_src + 16'd1;
              end
            endcase
          end
          we = 1'b1; wdata = ob;
          produced_next = produced + 17'd1;
          run_left_next = rl_dec;
          if (rl_dec == 11'd0) phase_next = PH_HDR;
          else if (phase == PH_LITH) phase_next = PH_LITW;
        end
      end else st = lzcsd_pkg::ST_NEED;
    end else if (phase == PH_RUN || phase == PH_LITH) begin
      st = lzcsd_pkg::ST_BUSY;
    end else begin
      if (consumed != 16'hFFFF) consumed_next = consumed + 16'd1;
      unique case (phase)
        PH_HDR: begin
          if (b == lzcsd_pkg::END_HDR) begin
            st = lzcsd_pkg::ST_END; phase_next = PH_END; failed_next = 1'b0;
          end else if (b[7:5] == 3'b111) begin
            cmd_next = b[4:2]; run_left_next = {1'b0, b[1:0], 8'd0};
            phase_next = PH_LONG;
          end else begin
            cmd_next = b[7:5]; run_left_next = {6'd0, b[4:0]} + 11'd1;
            phase_next = (b[7:5] == lzcsd_pkg::CMD_LIT) ? PH_LITW : PH_OPA;
          end
        end
        PH_LONG: begin
          run_left_next = run_left + {3'd0, b} + 11'd1;
          phase_next = (cmd == lzcsd_pkg::CMD_LIT) ? PH_LITW : PH_OPA;
        end
        PH_OPA: begin
          if (cmd >= lzcsd_pkg::CMD_BACK) begin
            if (b == 8'd0 || {9'd0, b} > produced) begin
              st = lzcsd_pkg::ST_ERR; phase_next = PH_END; failed_next = 1'b1;
            end else begin
              src_next = produced[15:0] - {8'd0, b}; phase_next = PH_RUN;
            end
          end else if (cmd >= lzcsd_pkg::CMD_ABS) begin
            src_next = {8'd0, b}; phase_next = PH_OPB;
          end else begin
            ff_next = b; parity_next = 1'b0;
            phase_next = (cmd == lzcsd_pkg::CMD_WORD) ? PH_OPB : PH_RUN;
          end
        end
        PH_OPB: begin
          if (cmd >= lzcsd_pkg::CMD_ABS) begin
            src_next = {b, copy_src[7:0]};
            if ({1'b0, b, copy_src[7:0]} >= produced) begin
              st = lzcsd_pkg::ST_ERR; phase_next = PH_END; failed_next = 1'b1;
            end else phase_next = PH_RUN;
          end else begin
            fs_next = b; phase_next = PH_RUN;
          end
        end
        default: begin
          ff_next = b; phase_next = PH_LITH;
        end
      endcase
    end
    if (!acc) begin
      phase_next = phase; failed_next = failed; produced_next = produced;
      consumed_next = consumed; cmd_next = cmd; run_left_next = run_left;
      ff_next = fill_first; fs_next = fill_second; src_next = copy_src;
      parity_next = parity; we = 1'b0;
    end
  end

  // Look-ahead read of the next copy source; forward a same-cycle write
  assign re = 1'b1;
  assign raddr = src_next[AW-1:0];

  always_ff @(posedge clk) begin
    rd_src <= src_next;
    fwd <= we && (waddr == src_next[AW-1:0]);
    fwd_data <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HDR; failed <= 1'b0; produced <= 17'd0; consumed <= 16'd0;
      cmd <= 3'd0; run_left <= 11'd0; fill_first <= 8'd0; fill_second <= 8'd0;
      copy_src <= 16'd0; parity <= 1'b0; rsp.valid <= 1'b0;
    end else begin
      phase <= phase_next; failed <= failed_next; produced <= produced_next;
      consumed <= consumed_next; cmd <= cmd_next; run_left <= run_left_next;
      fill_first <= ff_next; fill_second <= fs_next; copy_src <= src_next;
      parity <= parity_next;
      if (acc) rsp.valid <= 1'b1;
      else if (rsp.ready) rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      rsp.status <= st; rsp.out_byte <= ob; rsp.out_count <= produced_next;
    end
  end

  // Checks
  a_cnt_step: assert property (@(posedge clk) disable iff (rst)
    produced != $past(produced) |-> produced == $past(produced) + 17'd1)
    else $error("produced count jumped");
  a_data_cnt: assert property (@(posedge clk) disable iff (rst)
    acc && st == lzcsd_pkg::ST_DATA |=> rsp.out_count == $past(produced) + 17'd1)
    else $error("count not advanced with data");
  a_end_hold: assert property (@(posedge clk) disable iff (rst)
    phase == PH_END |=> phase == PH_END)
    else $error("left end state");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !acc |=> produced == $past(produced) && phase == $past(phase))
    else $error("state moved without transfer");
endmodule

>>> tb/tb_lz_command_stream_decompressor_core.sv
`timescale 1ns / 1ps
module tb_lz_command_stream_decompressor_core;

  typedef enum logic [2:0] {
    PH_HDR  = 3'd0,
    PH_LONG = 3'd1,
    PH_OPA  = 3'd2,
    PH_OPB  = 3'd3,
    PH_RUN  = 3'd4,
    PH_LITW = 3'd5,
    PH_LITH = 3'd6,
    PH_END  = 3'd7
  } phase_t;

  typedef struct packed {
    lzcsd_pkg::status_t status;
    logic [7:0]         out_byte;
    logic [16:0]        out_count;
  } decode_rsp_t;

  localparam int RANDOM_ITEMS = 700;
  localparam int IDLE_LIMIT = 4000;

  // Tracks the decoder state and holds the responses still to come out.
  class decode_tracker;
    logic [7:0]      hist [lzcsd_pkg::HIST_DEPTH_DEF];
    logic [16:0]     produced;
    logic [15:0]     consumed;
    phase_t          phase;
    lzcsd_pkg::cmd_t cmd;
    logic [10:0]     run_left;
    logic [7:0]      fill_a;
    logic [7:0]      fill_b;
    logic [15:0]     src;
    logic            parity;
    bit              failed;
    int              mismatches;
    decode_rsp_t     pending_results [$];

    function new();
      produced = '0;
      consumed = '0;
      phase = PH_HDR;
      cmd = lzcsd_pkg::CMD_LIT;
      run_left = '0;
      fill_a = '0;
      fill_b = '0;
      src = '0;
      parity = 1'b0;
      failed = 1'b0;
      mismatches = 0;
    endfunction

    function lzcsd_pkg::status_t finish(bit err);
      phase = PH_END;
      failed = err;
      return err ? lzcsd_pkg::ST_ERR : lzcsd_pkg::ST_END;
    endfunction

    function void enter_command();
      phase = (cmd == lzcsd_pkg::CMD_LIT) ? PH_LITW : PH_OPA;
    endfunction

    function lzcsd_pkg::status_t feed(logic [7:0] b);
      if (consumed != 16'hFFFF) consumed++;
      case (phase)
        PH_HDR: begin
          if (b == lzcsd_pkg::END_HDR) return finish(1'b0);
          if (b[7:5] == 3'b111) begin
            cmd = lzcsd_pkg::cmd_t'(b[4:2]);
            run_left = {1'b0, b[1:0], 8'h00};
            phase = PH_LONG;
          end else begin
            cmd = lzcsd_pkg::cmd_t'(b[7:5]);
            run_left = 11'(b[4:0]) + 11'd1;
            enter_command();
          end
        end
        PH_LONG: begin
          run_left = run_left + 11'(b) + 11'd1;
          enter_command();
        end
        PH_OPA: begin
          if (cmd == lzcsd_pkg::CMD_BACK || cmd == lzcsd_pkg::CMD_IBCK) begin
            if (b == 8'h00 || 17'(b) > produced) return finish(1'b1);
            src = 16'(produced - 17'(b));
            phase = PH_RUN;
          end else if (cmd == lzcsd_pkg::CMD_ABS || cmd == lzcsd_pkg::CMD_IABS) begin
            src = {8'h00, b};
            phase = PH_OPB;
          end else begin
            fill_a = b;
            parity = 1'b0;
            phase = (cmd == lzcsd_pkg::CMD_WORD) ? PH_OPB : PH_RUN;
          end
        end
        PH_OPB: begin
          if (cmd == lzcsd_pkg::CMD_ABS || cmd == lzcsd_pkg::CMD_IABS) begin
            src = {b, src[7:0]};
            if (17'(src) >= produced) return finish(1'b1);
          end else begin
            fill_b = b;
          end
          phase = PH_RUN;
        end
        default: begin
          fill_a = b;
          phase = PH_LITH;
        end
      endcase
      return lzcsd_pkg::ST_ACC;
    endfunction

    function lzcsd_pkg::status_t pull(output logic [7:0] v);
      v = '0;
      if (produced >= 17'(lzcsd_pkg::HIST_DEPTH_DEF)) return finish(1'b0);
      if (phase == PH_LITH) begin
        v = fill_a;
      end else begin
        case (cmd)
          lzcsd_pkg::CMD_FILL: v = fill_a;
          lzcsd_pkg::CMD_WORD: begin
            v = parity ? fill_b : fill_a;
            parity = ~parity;
          end
          lzcsd_pkg::CMD_INC: begin
            v = fill_a;
            fill_a = fill_a + 8'd1;
          end
          lzcsd_pkg::CMD_ABS, lzcsd_pkg::CMD_BACK: begin
            v = hist[src];
            src = src + 16'd1;
          end
          default: begin
            v = ~hist[src];
            src = src + 16'd1;
          end
        endcase
      end
      hist[produced[15:0]] = v;
      produced++;
      if (run_left != 0) run_left--;
      if (run_left == 0) phase = PH_HDR;
      else if (phase == PH_LITH) phase = PH_LITW;
      return lzcsd_pkg::ST_DATA;
    endfunction

    // Predict the response to one accepted request.
    function void note_request(logic t, logic [7:0] b);
      decode_rsp_t r;
      logic [7:0] v;
      v = '0;
      if (phase == PH_END) r.status = failed ? lzcsd_pkg::ST_ERR : lzcsd_pkg::ST_END;
      else if (phase == PH_HDR && 32'(consumed) >= lzcsd_pkg::MAX_IN_DEF)
        r.status = finish(1'b0);
      else if (t) begin
        if (phase == PH_RUN || phase == PH_LITH) r.status = pull(v);
        else r.status = lzcsd_pkg::ST_NEED;
      end else begin
        if (phase == PH_RUN || phase == PH_LITH) r.status = lzcsd_pkg::ST_BUSY;
        else r.status = feed(b);
      end
      r.out_byte = v;
      r.out_count = produced;
      pending_results.insert(pending_results.size(), r);
    endfunction

    function void check_result(logic [2:0] st, logic [7:0] ob, logic [16:0] cnt);
      decode_rsp_t e;
      if (pending_results.size() == 0) begin
        $error("unexpected response: status %0d byte %0h count %0d", st, ob, cnt);
        mismatches++;
        return;
      end
      e = pending_results.pop_front();
      if (st !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, st);
        mismatches++;
      end
      if (ob !== e.out_byte) begin
        $error("out_byte: expected %0h, got %0h", e.out_byte, ob);
        mismatches++;
      end
      if (cnt !== e.out_count) begin
        $error("out_count: expected %0d, got %0d", e.out_count, cnt);
        mismatches++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  lzcsd_req_if req ();
  lzcsd_rsp_if rsp ();

  lz_command_stream_decompressor_core u_top (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  always #10 clk = ~clk;

  decode_tracker tracker = new();
  int n_req = 0;
  int n_rsp = 0;
  int idle_cycles = 0;
  logic [7:0] abs_hi = '0;
  int ending = 0;

  // Stretches of items with no idling on either side.
  function automatic int pick_gap(int idx);
    if ((idx / 64) % 4 == 1) return 0;
    return $urandom_range(19);
  endfunction

  task automatic issue(logic t, logic [7:0] b);
    int g;
    logic acc;
    g = pick_gap(n_req);
    if (g > 0) begin
      req.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    req.valid <= 1'b1;
    req.req_type <= t;
    req.in_byte <= b;
    do begin
      @(negedge clk);
      acc = req.ready;
      @(posedge clk);
    end while (!acc);
    tracker.note_request(t, b);
    n_req++;
  endtask

  // Well-formed next compressed byte for the current decoder phase.
  function automatic logic [7:0] next_stream_byte();
    logic [2:0] c;
    logic [1:0] hi;
    logic [15:0] addr;
    int lim;
    case (tracker.phase)
      PH_HDR: begin
        c = 3'($urandom_range(7));
        if (tracker.produced == 0 && c >= 3'(lzcsd_pkg::CMD_ABS)) c = 3'(lzcsd_pkg::CMD_LIT);
        if (c == 3'(lzcsd_pkg::CMD_IBCK) || $urandom_range(5) == 0) begin
          hi = ($urandom_range(30) == 0) ? 2'($urandom_range(3)) : 2'd0;
          if (c == 3'(lzcsd_pkg::CMD_IBCK) && hi == 2'd3) hi = 2'd2;
          return {3'b111, c, hi};
        end
        return {c, 5'($urandom_range(31))};
      end
      PH_LONG: return (tracker.run_left != 0) ? 8'($urandom) : 8'($urandom_range(63));
      PH_OPA: begin
        if (tracker.cmd == lzcsd_pkg::CMD_BACK || tracker.cmd == lzcsd_pkg::CMD_IBCK) begin
          lim = (tracker.produced > 255) ? 255 : int'(tracker.produced);
          return 8'($urandom_range(lim, 1));
        end
        if (tracker.cmd == lzcsd_pkg::CMD_ABS || tracker.cmd == lzcsd_pkg::CMD_IABS) begin
          if ($urandom_range(1) == 0 || tracker.produced <= 300)
            addr = 16'($urandom_range(int'(tracker.produced) - 1));
          else
            addr = 16'($urandom_range(int'(tracker.produced) - 1,
                                      int'(tracker.produced) - 300));
          abs_hi = addr[15:8];
          return addr[7:0];
        end
        return 8'($urandom);
      end
      PH_OPB: begin
        if (tracker.cmd == lzcsd_pkg::CMD_ABS || tracker.cmd == lzcsd_pkg::CMD_IABS)
          return abs_hi;
        return 8'($urandom);
      end
      default: return 8'($urandom);
    endcase
  endfunction

  // One request: mostly the right kind for the phase, some noise.
  task automatic step_random();
    if (tracker.phase == PH_RUN || tracker.phase == PH_LITH) begin
      if ($urandom_range(19) == 0) issue(1'b0, 8'($urandom));
      else issue(1'b1, 8'($urandom));
    end else if (tracker.phase == PH_END || $urandom_range(12) == 0) begin
      issue(1'b1, 8'($urandom));
    end else begin
      issue(1'b0, next_stream_byte());
    end
  endtask

  // Feed one byte, then drain every decoded byte it makes available.
  task automatic feed_and_drain(logic [7:0] b);
    issue(1'b0, b);
    while (tracker.phase == PH_RUN || tracker.phase == PH_LITH) issue(1'b1, 8'h00);
  endtask

  // Receiver: random stalls, check every transfer.
  initial begin
    int g;
    logic t;
    logic [2:0] st;
    logic [7:0] ob;
    logic [16:0] cnt;
    rsp.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      g = pick_gap(n_rsp);
      if (g > 0) begin
        rsp.ready <= 1'b0;
        repeat (g) @(posedge clk);
      end
      rsp.ready <= 1'b1;
      do begin
        @(negedge clk);
        t = rsp.valid;
        st = rsp.status;
        ob = rsp.out_byte;
        cnt = rsp.out_count;
        @(posedge clk);
      end while (!t);
      tracker.check_result(st, ob, cnt);
      n_rsp++;
    end
  end

  // Watchdog on cycles with no transfer on either channel.
  always @(negedge clk) begin
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_lz_command_stream_decompressor_core NOT OK");
      $finish;
    end
  end

  initial begin
    req.valid = 1'b0;
    req.req_type = 1'b0;
    req.in_byte = 8'h00;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: pull before any input, every command, wrap, overlap, max length.
    issue(1'b1, 8'h00);
    issue(1'b0, 8'h01);
    issue(1'b0, 8'h00);
    issue(1'b0, 8'h55);
    issue(1'b1, 8'h00);
    feed_and_drain(8'hFF);
    feed_and_drain(8'h21); feed_and_drain(8'hAA);
    feed_and_drain(8'h41); feed_and_drain(8'h12); feed_and_drain(8'h34);
    feed_and_drain(8'h7F); feed_and_drain(8'hFE);
    feed_and_drain(8'h83); feed_and_drain(8'h00); feed_and_drain(8'h00);
    feed_and_drain(8'hA1); feed_and_drain(8'h01); feed_and_drain(8'h00);
    feed_and_drain(8'hC3); feed_and_drain(8'h01);
    feed_and_drain(8'hFC); feed_and_drain(8'h03); feed_and_drain(8'h02);
    feed_and_drain(8'hE7); feed_and_drain(8'hFF); feed_and_drain(8'h5A);

    // Random stream, with one full drain of the response side midway.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS / 2) begin
        req.valid <= 1'b0;
        @(posedge clk);
        while (tracker.pending_results.size() != 0) @(posedge clk);
      end
      step_random();
    end

    // Close the stream one of three ways.
    while (tracker.phase != PH_HDR) step_random();
    ending = $urandom_range(2);
    case (ending)
      0: issue(1'b0, lzcsd_pkg::END_HDR);
      1: begin
        issue(1'b0, 8'hC0);
        issue(1'b0, 8'h00);
      end
      default: begin
        issue(1'b0, 8'h80);
        issue(1'b0, tracker.produced[7:0]);
        issue(1'b0, tracker.produced[15:8]);
      end
    endcase
    repeat (4) issue(1'($urandom), 8'($urandom));
    req.valid <= 1'b0;

    while (tracker.pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("requests %0d, responses %0d, decoded bytes %0d", n_req, n_rsp,
             tracker.produced);
    $display("stream closed by %s", (ending == 0) ? "end header" :
             (ending == 1) ? "bad backward offset" : "bad absolute address");
    if (tracker.mismatches == 0 && tracker.pending_results.size() == 0) begin
      $display("tb_lz_command_stream_decompressor_core OK");
    end else begin
      $display("tb_lz_command_stream_decompressor_core NOT OK");
    end
    $finish;
  end
endmodule
